@@ rtl/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

	// Screen geometry defaults.
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// Port field widths.
	localparam int FUNC_W      = 2;
	localparam int CHAR_W      = 8;
	localparam int CELL_ADDR_W = 11;
	localparam int CELL_W      = 16;
	localparam int ROW_OUT_W   = 5;
	localparam int COL_OUT_W   = 7;
	localparam int COLOUR_W    = 4;
	localparam int CFG_INDEX_W = 1;

	// Function codes.
	localparam logic [FUNC_W-1:0] FUNC_PRINT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// Control characters.
	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

	// Cell written by a screen clear: blank, white on black.
	localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0F20;

	// Reset colours.
	localparam logic [COLOUR_W-1:0] FG_RESET = 4'd15;
	localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_FG = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BG = 1'b1;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_TAB,
		ST_SC_RD,
		ST_SC_WR,
		ST_SC_BLANK,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ rtl/tcce_screen_mem.sv @@
// ----------------------------------------------------------------------------
// tcce_screen_mem
// Screen cell memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_screen_mem #(
	parameter int DEPTH  = tcce_pkg::DEF_ROWS * tcce_pkg::DEF_COLUMNS,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [ADDR_W-1:0]           wr_addr,
	input  wire logic [tcce_pkg::CELL_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [ADDR_W-1:0]           rd_addr,
	output logic      [tcce_pkg::CELL_W-1:0] rd_data
);

	logic [tcce_pkg::CELL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next enabled read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/text_console_cursor_engine_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Text console over a screen of ROWS by COLUMNS cells with a cursor.
// ----------------------------------------------------------------------------
// Input beats carry func, char_code and cell_address on in_valid/in_stall;
// each beat gives exactly one result beat of read_data, cursor_row and
// cursor_column on out_valid/out_stall. The block works on one beat at a
// time and holds in_stall high until its result is in the output register.
// A read, return, unused function code, newline without scroll or backspace
// at the origin goes straight to the result register; a printed character or
// any other backspace first writes its cell. A tab blanks cells up to the next
// tab stop. A scroll reads each moved cell and writes it one row up, then
// blanks the bottom row, before the newline, character or tab finishes as
// above. A clear writes one cell per cycle. The next beat can be taken in the
// cycle in which out_valid rises, at the earliest.
// After reset the block runs a clearing pass that fills the screen with
// white-on-black blanks; in_stall stays high meanwhile.
// Colour writes are taken at any time. A stalled result stays in the output
// register; a finished item then waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_unit #(
	parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [tcce_pkg::FUNC_W-1:0]      func,
	input  wire logic [tcce_pkg::CHAR_W-1:0]      char_code,
	input  wire logic [tcce_pkg::CELL_ADDR_W-1:0] cell_address,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [tcce_pkg::CELL_W-1:0]      read_data,
	output logic      [tcce_pkg::ROW_OUT_W-1:0]   cursor_row,
	output logic      [tcce_pkg::COL_OUT_W-1:0]   cursor_column,
	input  wire logic                             cfg_write_en,
	input  wire logic [tcce_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tcce_pkg::COLOUR_W-1:0]    cfg_data
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int CMP_W  = (ADDR_W > tcce_pkg::CELL_ADDR_W) ? ADDR_W : tcce_pkg::CELL_ADDR_W;
	localparam int ROWX_W = (ROW_W > tcce_pkg::ROW_OUT_W) ? ROW_W : tcce_pkg::ROW_OUT_W;
	localparam int COLX_W = (COL_W > tcce_pkg::COL_OUT_W) ? COL_W : tcce_pkg::COL_OUT_W;

	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELLS - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  COL_WRAP  = COL_W'(COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

	tcce_pkg::state_t state_q, state_d, after_q;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [tcce_pkg::CHAR_W-1:0]   ch_q;
	logic                          adv_q;
	logic                          rd_sel_q;
	logic [tcce_pkg::COLOUR_W-1:0] fg_q, bg_q;
	logic                          out_valid_q;
	logic [tcce_pkg::CELL_W-1:0]   read_data_q;
	logic [ROWX_W-1:0]             row_x;
	logic [COLX_W-1:0]             col_x;

	logic                        wr_en, rd_en;
	logic [ADDR_W-1:0]           wr_addr, rd_addr;
	logic [tcce_pkg::CELL_W-1:0] wr_data, rd_data;

	logic              accept, out_free;
	logic              is_nl, is_cr, is_bs, is_tab, col_pend, wrap_nl;
	logic              on_last_row, tab_end, addr_ok;
	logic [CMP_W-1:0]  addr_ext;
	logic [COL_W-1:0]  col_inc;
	logic [tcce_pkg::CELL_W-1:0] colour_cell;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign is_nl    = (char_code == tcce_pkg::CH_NL);
	assign is_cr    = (char_code == tcce_pkg::CH_CR);
	assign is_bs    = (char_code == tcce_pkg::CH_BS);
	assign is_tab   = (char_code == tcce_pkg::CH_TAB);
	assign col_pend = (col_q == COL_WRAP);
	// A newline is due for a newline byte, or for a printing byte or tab
	// that arrives at the pending-wrap column.
	assign wrap_nl     = is_nl || (!is_cr && !is_bs && col_pend);
	assign on_last_row = (row_q == LAST_ROW);

	assign col_inc = col_q + COL_W'(1);
	assign tab_end = (col_inc[1:0] == 2'b00) || (col_inc == COL_WRAP);

	assign addr_ext = CMP_W'(cell_address);
	assign addr_ok  = (addr_ext < CMP_W'(CELLS));

	assign colour_cell = {bg_q, fg_q, tcce_pkg::CHAR_W'(0)};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcce_pkg::ST_INIT: begin
				if (ptr_q == LAST_CELL) state_d = tcce_pkg::ST_IDLE;
			end
			tcce_pkg::ST_CLEAR: begin
				if (ptr_q == LAST_CELL) state_d = tcce_pkg::ST_DONE;
			end
			tcce_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (func)
						tcce_pkg::FUNC_PRINT: begin
							if (wrap_nl && on_last_row) begin
								state_d = tcce_pkg::ST_SC_RD;
							end else if (is_nl || is_cr) begin
								state_d = tcce_pkg::ST_DONE;
							end else if (is_bs) begin
								if (col_q == '0 && row_q == '0) state_d = tcce_pkg::ST_DONE;
								else state_d = tcce_pkg::ST_PUT;
							end else if (is_tab) begin
								state_d = tcce_pkg::ST_TAB;
							end else begin
								state_d = tcce_pkg::ST_PUT;
							end
						end
						tcce_pkg::FUNC_CLEAR: state_d = tcce_pkg::ST_CLEAR;
						default:              state_d = tcce_pkg::ST_DONE;
					endcase
				end
			end
			tcce_pkg::ST_PUT: state_d = tcce_pkg::ST_DONE;
			tcce_pkg::ST_TAB: begin
				if (tab_end) state_d = tcce_pkg::ST_DONE;
			end
			tcce_pkg::ST_SC_RD: state_d = tcce_pkg::ST_SC_WR;
			tcce_pkg::ST_SC_WR: begin
				if (ptr_q == LAST_COPY) state_d = tcce_pkg::ST_SC_BLANK;
				else state_d = tcce_pkg::ST_SC_RD;
			end
			tcce_pkg::ST_SC_BLANK: begin
				if (ptr_q == LAST_CELL) state_d = after_q;
			end
			tcce_pkg::ST_DONE: begin
				if (out_free) state_d = tcce_pkg::ST_IDLE;
			end
			default: state_d = tcce_pkg::ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = tcce_pkg::CLEAR_CELL;
		rd_en   = 1'b0;
		rd_addr = ptr_q + ROW_STEP;
		unique case (state_q)
			tcce_pkg::ST_INIT, tcce_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			tcce_pkg::ST_IDLE: begin
				rd_en   = accept && (func == tcce_pkg::FUNC_READ) && addr_ok;
				rd_addr = addr_ext[ADDR_W-1:0];
			end
			tcce_pkg::ST_PUT, tcce_pkg::ST_TAB: begin
				wr_en   = 1'b1;
				wr_addr = base_q + ADDR_W'(col_q);
				wr_data = colour_cell | tcce_pkg::CELL_W'(ch_q);
			end
			tcce_pkg::ST_SC_RD: begin
				rd_en = 1'b1;
			end
			tcce_pkg::ST_SC_WR: begin
				wr_en   = 1'b1;
				wr_data = rd_data;
			end
			tcce_pkg::ST_SC_BLANK: begin
				wr_en   = 1'b1;
				wr_data = colour_cell | tcce_pkg::CELL_W'(tcce_pkg::CH_BLANK);
			end
			tcce_pkg::ST_DONE: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcce_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcce_pkg::FG_RESET;
			bg_q <= tcce_pkg::BG_RESET;
		end else if (cfg_write_en) begin
			if (cfg_index == tcce_pkg::CFG_FG) fg_q <= cfg_data;
			if (cfg_index == tcce_pkg::CFG_BG) bg_q <= cfg_data;
		end
	end

	// Cursor, sweep pointer and per-item control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			base_q   <= '0;
			ptr_q    <= '0;
			ch_q     <= tcce_pkg::CH_BLANK;
			adv_q    <= 1'b0;
			rd_sel_q <= 1'b0;
			after_q  <= tcce_pkg::ST_DONE;
		end else begin
			case (state_q)
				tcce_pkg::ST_INIT, tcce_pkg::ST_CLEAR, tcce_pkg::ST_SC_WR,
				tcce_pkg::ST_SC_BLANK: begin
					ptr_q <= ptr_q + ADDR_W'(1);
				end
				tcce_pkg::ST_IDLE: begin
					if (accept) begin
						ptr_q    <= '0;
						rd_sel_q <= (func == tcce_pkg::FUNC_READ) && addr_ok;
						ch_q     <= (is_bs || is_tab) ? tcce_pkg::CH_BLANK : char_code;
						adv_q    <= !is_bs;
						if (is_nl) after_q <= tcce_pkg::ST_DONE;
						else if (is_tab) after_q <= tcce_pkg::ST_TAB;
						else after_q <= tcce_pkg::ST_PUT;
						if (func == tcce_pkg::FUNC_CLEAR) begin
							row_q  <= '0;
							col_q  <= '0;
							base_q <= '0;
						end else if (func == tcce_pkg::FUNC_PRINT) begin
							if (wrap_nl) begin
								col_q <= '0;
								if (!on_last_row) begin
									row_q  <= row_q + ROW_W'(1);
									base_q <= base_q + ROW_STEP;
								end
							end else if (is_cr) begin
								col_q <= '0;
							end else if (is_bs) begin
								// At column zero the cursor goes to the end of the
								// row above, unless it is already on the top row.
								if (col_q == '0) begin
									if (row_q != '0) begin
										row_q  <= row_q - ROW_W'(1);
										base_q <= base_q - ROW_STEP;
										col_q  <= COL_LAST;
									end
								end else begin
									col_q <= col_q - COL_W'(1);
								end
							end
						end
					end
				end
				tcce_pkg::ST_PUT: begin
					if (adv_q) col_q <= col_inc;
				end
				tcce_pkg::ST_TAB: begin
					col_q <= col_inc;
				end
				default: begin
					ptr_q <= ptr_q;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tcce_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcce_pkg::ST_DONE && out_free) begin
			read_data_q <= rd_sel_q ? rd_data : '0;
			row_x       <= ROWX_W'(row_q);
			col_x       <= COLX_W'(col_q);
		end
	end

	tcce_screen_mem #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_stall      = (state_q != tcce_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign cursor_row    = row_x[tcce_pkg::ROW_OUT_W-1:0];
	assign cursor_column = col_x[tcce_pkg::COL_OUT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/tcce_checker.sv @@
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_checker #(
	parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_stall,
	input wire logic                             out_valid,
	input wire logic                             out_stall,
	input wire logic [tcce_pkg::CELL_W-1:0]      read_data,
	input wire logic [tcce_pkg::ROW_OUT_W-1:0]   cursor_row,
	input wire logic [tcce_pkg::COL_OUT_W-1:0]   cursor_column
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data)
			&& $stable(cursor_row) && $stable(cursor_column))
		else $error("result beat changed while stalled");

	// The block works on one beat at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a beat");

	// A new result appears only after the block was busy with a beat.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(cursor_column) <= COLUMNS)
		else $error("cursor column beyond pending wrap");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(cursor_row) < ROWS)
		else $error("cursor row beyond screen");

endmodule

bind text_console_cursor_engine_unit tcce_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcce_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.read_data     (read_data),
	.cursor_row    (cursor_row),
	.cursor_column (cursor_column)
);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console cursor engine. A directed table
// exercises the edges of the cursor logic, then biased random traffic drives
// scrolls, wraps and reads through several colour and flow-control phases.
// Each result beat is checked against a behavioral screen and cursor model or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int COLUMNS  = tcce_pkg::DEF_COLUMNS;
	localparam int ROWS     = tcce_pkg::DEF_ROWS;
	localparam int CELLS    = COLUMNS * ROWS;
	localparam int TAB_STOP = 4;
	localparam int N_TABLE  = 25;
	localparam int PHASE_ITEMS = 240;

	// The block decodes only three function codes; the fourth must do nothing.
	localparam logic [tcce_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic [tcce_pkg::FUNC_W-1:0]      func;
		logic [tcce_pkg::CHAR_W-1:0]      ch;
		logic [tcce_pkg::CELL_ADDR_W-1:0] addr;
	} console_cmd_t;

	typedef struct packed {
		logic [tcce_pkg::CELL_W-1:0]    data;
		logic [tcce_pkg::ROW_OUT_W-1:0] row;
		logic [tcce_pkg::COL_OUT_W-1:0] col;
	} console_result_t;

	typedef struct packed {
		logic [tcce_pkg::FUNC_W-1:0]      func;
		logic [tcce_pkg::CHAR_W-1:0]      ch;
		logic [tcce_pkg::CELL_ADDR_W-1:0] addr;
		logic                             typed;
		logic [tcce_pkg::CELL_W-1:0]      data;
		logic [tcce_pkg::ROW_OUT_W-1:0]   row;
		logic [tcce_pkg::COL_OUT_W-1:0]   col;
	} directed_row_t;

	// Rows with typed set carry their own expected result; the rest use the model.
	localparam directed_row_t CURSOR_TABLE [N_TABLE] = '{
		'{tcce_pkg::FUNC_READ,  8'h00, 11'd0,    1'b1, tcce_pkg::CLEAR_CELL, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_READ,  8'h00, 11'd1999, 1'b1, tcce_pkg::CLEAR_CELL, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_READ,  8'h00, 11'd2000, 1'b1, 16'h0000, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_READ,  8'hFF, 11'd2047, 1'b1, 16'h0000, 5'd0, 7'd0},
		'{FUNC_SPARE,           8'hFF, 11'd2047, 1'b1, 16'h0000, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_BS, 11'd0, 1'b1, 16'h0000, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_PRINT, 8'h41, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd1},
		'{tcce_pkg::FUNC_READ,  8'h00, 11'd0,    1'b1, 16'h0F41, 5'd0, 7'd1},
		'{tcce_pkg::FUNC_PRINT, 8'h00, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd2},
		'{tcce_pkg::FUNC_PRINT, 8'hFF, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd3},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_TAB, 11'd0, 1'b0, 16'h0000, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_TAB, 11'd0, 1'b0, 16'h0000, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_BS, 11'd0, 1'b1, 16'h0000, 5'd0, 7'd7},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_CR, 11'd0, 1'b1, 16'h0000, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_BS, 11'd0, 1'b1, 16'h0000, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_NL, 11'd0, 1'b1, 16'h0000, 5'd1, 7'd0},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_BS, 11'd0, 1'b1, 16'h0000, 5'd0, 7'd79},
		'{tcce_pkg::FUNC_PRINT, 8'h78, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd80},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_BS, 11'd0, 1'b1, 16'h0000, 5'd0, 7'd79},
		'{tcce_pkg::FUNC_PRINT, 8'h79, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd80},
		'{tcce_pkg::FUNC_PRINT, tcce_pkg::CH_TAB, 11'd0, 1'b0, 16'h0000, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_READ,  8'h00, 11'd79,   1'b1, 16'h0F79, 5'd1, 7'd4},
		'{tcce_pkg::FUNC_READ,  8'h00, 11'd2,    1'b1, 16'h0FFF, 5'd1, 7'd4},
		'{tcce_pkg::FUNC_CLEAR, 8'h00, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd0},
		'{tcce_pkg::FUNC_READ,  8'h00, 11'd2,    1'b1, tcce_pkg::CLEAR_CELL, 5'd0, 7'd0}
	};

	logic                             clk;
	logic                             arst_n        = 1'b0;
	logic                             in_valid      = 1'b0;
	logic                             in_stall;
	logic [tcce_pkg::FUNC_W-1:0]      func          = tcce_pkg::FUNC_PRINT;
	logic [tcce_pkg::CHAR_W-1:0]      char_code     = '0;
	logic [tcce_pkg::CELL_ADDR_W-1:0] cell_address  = '0;
	logic                             out_valid;
	logic                             out_stall     = 1'b0;
	logic [tcce_pkg::CELL_W-1:0]      read_data;
	logic [tcce_pkg::ROW_OUT_W-1:0]   cursor_row;
	logic [tcce_pkg::COL_OUT_W-1:0]   cursor_column;
	logic                             cfg_write_en  = 1'b0;
	logic [tcce_pkg::CFG_INDEX_W-1:0] cfg_index     = tcce_pkg::CFG_FG;
	logic [tcce_pkg::COLOUR_W-1:0]    cfg_data      = '0;

	text_console_cursor_engine_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.char_code     (char_code),
		.cell_address  (cell_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.cursor_row    (cursor_row),
		.cursor_column (cursor_column),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Screen model and cursor.
	logic [tcce_pkg::CELL_W-1:0]   screen_model [0:CELLS-1];
	int unsigned                   cur_row;
	int unsigned                   cur_col;
	logic [tcce_pkg::COLOUR_W-1:0] fg_colour;
	logic [tcce_pkg::COLOUR_W-1:0] bg_colour;

	console_result_t awaited_results [$];
	console_result_t head_result;
	int unsigned     mismatch_count = 0;
	int unsigned     result_index   = 0;
	int unsigned     sender_idle_pct = 0;
	int unsigned     recv_stall_pct  = 0;
	int unsigned     hold_left       = 0;
	int unsigned     line_burst      = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#300000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void put_cell(int unsigned r, int unsigned c,
			logic [tcce_pkg::CHAR_W-1:0] ch);
		if (r < ROWS && c < COLUMNS) begin
			screen_model[r * COLUMNS + c] = {bg_colour, fg_colour, ch};
		end
	endfunction

	function automatic void wipe_model();
		for (int i = 0; i < CELLS; i++) begin
			screen_model[i] = tcce_pkg::CLEAR_CELL;
		end
		cur_row = 0;
		cur_col = 0;
	endfunction

	// On the last row a newline scrolls everything up and blanks the bottom row.
	function automatic void advance_line();
		if (cur_row < ROWS - 1) begin
			cur_row++;
		end else begin
			for (int i = 0; i < CELLS - COLUMNS; i++) begin
				screen_model[i] = screen_model[i + COLUMNS];
			end
			for (int x = 0; x < COLUMNS; x++) begin
				put_cell(ROWS - 1, x, tcce_pkg::CH_BLANK);
			end
		end
		cur_col = 0;
	endfunction

	function automatic console_result_t console_step(console_cmd_t c);
		console_result_t r;
		int unsigned     n;
		r.data = '0;
		if (c.func == tcce_pkg::FUNC_PRINT) begin
			case (c.ch)
				tcce_pkg::CH_NL: advance_line();
				tcce_pkg::CH_CR: cur_col = 0;
				tcce_pkg::CH_BS: begin
					if (!(cur_col == 0 && cur_row == 0)) begin
						if (cur_col == 0) begin
							cur_row--;
							cur_col = COLUMNS;
						end
						cur_col--;
						put_cell(cur_row, cur_col, tcce_pkg::CH_BLANK);
					end
				end
				tcce_pkg::CH_TAB: begin
					if (cur_col >= COLUMNS) advance_line();
					n = TAB_STOP - (cur_col % TAB_STOP);
					while (n != 0 && cur_col < COLUMNS) begin
						put_cell(cur_row, cur_col, tcce_pkg::CH_BLANK);
						cur_col++;
						n--;
					end
				end
				default: begin
					if (cur_col >= COLUMNS) advance_line();
					put_cell(cur_row, cur_col, c.ch);
					cur_col++;
				end
			endcase
		end else if (c.func == tcce_pkg::FUNC_CLEAR) begin
			wipe_model();
		end else if (c.func == tcce_pkg::FUNC_READ) begin
			if (c.addr < CELLS) r.data = screen_model[c.addr];
		end
		r.row = tcce_pkg::ROW_OUT_W'(cur_row);
		r.col = tcce_pkg::COL_OUT_W'(cur_col);
		return r;
	endfunction

	// Newlines are frequent until the cursor reaches the bottom row, then rarer
	// so that scrolls happen regularly without dominating the run time. Long
	// bursts of text without returns push the cursor into the wrap column.
	function automatic console_cmd_t random_cmd();
		console_cmd_t c;
		int unsigned  pick;
		c.func = tcce_pkg::FUNC_PRINT;
		c.ch   = tcce_pkg::CHAR_W'($urandom_range(255));
		c.addr = tcce_pkg::CELL_ADDR_W'($urandom_range(2047));
		if (line_burst != 0) begin
			line_burst--;
			pick = $urandom_range(99);
			if (pick < 15) c.ch = tcce_pkg::CH_TAB;
			else if (pick < 20) c.ch = tcce_pkg::CH_BS;
			else if (c.ch == tcce_pkg::CH_NL || c.ch == tcce_pkg::CH_CR)
				c.ch = tcce_pkg::CH_BLANK;
			return c;
		end
		pick = $urandom_range(999);
		if (pick < 4) begin
			c.func = tcce_pkg::FUNC_CLEAR;
		end else if (pick < 14) begin
			c.func = FUNC_SPARE;
		end else if (pick < 160) begin
			c.func = tcce_pkg::FUNC_READ;
			if ($urandom_range(9) != 0)
				c.addr = tcce_pkg::CELL_ADDR_W'($urandom_range(CELLS - 1));
		end else if (pick < 190) begin
			line_burst = $urandom_range(90, 60);
		end else if (pick < 250) begin
			c.ch = tcce_pkg::CH_CR;
		end else if (pick < 330) begin
			c.ch = tcce_pkg::CH_BS;
		end else if (pick < 410) begin
			c.ch = tcce_pkg::CH_TAB;
		end else if (pick < (cur_row == ROWS - 1 ? 450 : 570)) begin
			c.ch = tcce_pkg::CH_NL;
		end
		return c;
	endfunction

	task automatic send_cmd(input console_cmd_t c, input logic typed,
			input console_result_t want);
		console_result_t predicted;
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= c.func;
		char_code    <= c.ch;
		cell_address <= c.addr;
		do @(posedge clk); while (in_stall);
		predicted = console_step(c);
		awaited_results.push_back(typed ? want : predicted);
	endtask

	// Colour writes are only issued once every outstanding result has drained.
	task automatic run_phase(input int unsigned sidle, input int unsigned rstall,
			input int unsigned hold, input logic [tcce_pkg::COLOUR_W-1:0] fg,
			input logic [tcce_pkg::COLOUR_W-1:0] bg);
		while (awaited_results.size() != 0) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= tcce_pkg::CFG_FG;
		cfg_data     <= fg;
		@(posedge clk);
		cfg_index <= tcce_pkg::CFG_BG;
		cfg_data  <= bg;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		fg_colour = fg;
		bg_colour = bg;
		sender_idle_pct = sidle;
		recv_stall_pct  = rstall;
		hold_left       = hold;
		repeat (PHASE_ITEMS) send_cmd(random_cmd(), 1'b0, '0);
		in_valid <= 1'b0;
	endtask

	// Result checking and receiver flow control.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_index++;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result beat %0d: data %h row %0d col %0d",
						result_index, read_data, cursor_row, cursor_column);
				end
			end else begin
				head_result = awaited_results.pop_front();
				if (read_data !== head_result.data || cursor_row !== head_result.row ||
						cursor_column !== head_result.col) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("beat %0d: expected %h/%0d/%0d, got %h/%0d/%0d",
							result_index, head_result.data, head_result.row,
							head_result.col, read_data, cursor_row, cursor_column);
					end
				end
			end
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
		end
	end

	initial begin
		directed_row_t   row;
		console_result_t want;
		console_cmd_t    cmd;
		wipe_model();
		fg_colour = tcce_pkg::FG_RESET;
		bg_colour = tcce_pkg::BG_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_TABLE; i++) begin
			row = CURSOR_TABLE[i];
			want = '{row.data, row.row, row.col};
			cmd  = '{row.func, row.ch, row.addr};
			send_cmd(cmd, row.typed, want);
		end
		in_valid <= 1'b0;

		// The first phase opens with a long receiver hold-off so the input backs up.
		run_phase(0, 0, 300, 4'd0, 4'd15);
		run_phase(87, 0, 0, 4'd15, 4'd15);
		run_phase(0, 87, 0, tcce_pkg::COLOUR_W'($urandom_range(15)),
			tcce_pkg::COLOUR_W'($urandom_range(15)));
		run_phase(23, 23, 0, 4'd15, 4'd0);
		run_phase(0, 0, 0, 4'd0, 4'd0);

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ text_console_cursor_engine_unit.f @@
rtl/tcce_pkg.sv
rtl/tcce_screen_mem.sv
rtl/text_console_cursor_engine_unit.sv
rtl/tcce_checker.sv
tb/testbench.sv
